/* src/mspt_pkg.sv */
package mspt_pkg;

  localparam int unsigned TICK_W  = 10;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned MARK_W  = 17;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned PORT_W  = 8;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CFG_A_W = 1;

  // stream payload widths
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 32;
  localparam int unsigned M_USER_W = 1;

  localparam logic [MARK_W-1:0] MARK_MAX  = '1;
  localparam logic [TIME_W-1:0] COUNT_MAX = '1;
  localparam logic [PORT_W-1:0] PORT_IDLE = 8'h00;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SETUP = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_PORT_OPEN = 1'b0,
    CFG_TICK_MS   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // perform setup, start or stop
    logic walk;   // visit one slot of a tick
    logic push;   // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic walk_last;
  } ctl_sts_t;

endpackage

/* src/mspt_ctrl.sv */
module mspt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output mspt_pkg::ctl_cmd_t cmd_o,
  input  mspt_pkg::ctl_sts_t sts_i
);
  import mspt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.is_tick ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || m_axis_tready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/mspt_dp.sv */
module mspt_dp #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mspt_pkg::CFG_A_W-1:0]    cfg_addr_i,
  input  logic [mspt_pkg::TICK_W-1:0]     cfg_wdata_i,
  input  logic [mspt_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [mspt_pkg::S_USER_W-1:0]   s_axis_tuser_i,
  output logic [mspt_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  output logic [mspt_pkg::M_USER_W-1:0]   m_axis_tuser_o,
  input  mspt_pkg::ctl_cmd_t              cmd_i,
  output mspt_pkg::ctl_sts_t              sts_o
);
  import mspt_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration
  logic              open_q;
  logic [TICK_W-1:0] tick_q;

  // captured request
  req_e              req_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CH_W-1:0]   chan_q;
  logic              al_q;
  logic              keep_q;
  logic [TIME_W-1:0] width_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] count_q;

  // slot table: flags and timing state
  logic [PORT_W-1:0] port_q, port_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [SLOTS-1:0]  run_q, run_d;
  logic [SLOTS-1:0]  pon_q, pon_d;
  logic [MARK_W-1:0] mark_q [SLOTS];
  logic [TIME_W-1:0] done_q [SLOTS];

  // slot table: settings, written by setup only
  logic [CH_W-1:0]   chan_mem   [SLOTS];
  logic              al_mem     [SLOTS];
  logic              keep_mem   [SLOTS];
  logic [TIME_W-1:0] width_mem  [SLOTS];
  logic [TIME_W-1:0] period_mem [SLOTS];
  logic [TIME_W-1:0] total_mem  [SLOTS];

  logic [IDX_W-1:0]  idx_q;
  logic              res_acc_q;
  logic [IDX_W-1:0]  res_given_q;
  logic [M_DATA_W-1:0] tdata_q;
  logic [M_USER_W-1:0] tuser_q;

  // free slot search
  logic              free_any;
  logic [IDX_W-1:0]  free_idx;

  // request decode
  logic              slot_ok;
  logic [IDX_W-1:0]  req_idx;
  logic              setup_ok, start_ok, stop_ok;

  // walk of one slot
  logic              w_act, w_was, w_next;
  logic [MARK_W-1:0] w_mark, w_base, w_new_mark;
  logic [MARK_W:0]   w_sum;
  logic [TIME_W-1:0] w_done;
  logic              w_start, w_end, w_finish;

  assign sts_o.is_tick   = (req_e'(s_axis_tuser_i) == REQ_TICK);
  assign sts_o.walk_last = (idx_q == IDX_W'(SLOTS - 1));

  always_comb begin
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_idx = IDX_W'(s);
      end
    end
  end
  assign free_any = ~&used_q;

  assign slot_ok  = (32'(slot_q) < SLOTS);
  assign req_idx  = slot_q[IDX_W-1:0];
  assign setup_ok = (req_q == REQ_SETUP) && open_q && free_any;
  assign start_ok = (req_q == REQ_START) && slot_ok && used_q[req_idx] && !run_q[req_idx];
  assign stop_ok  = (req_q == REQ_STOP) && slot_ok && used_q[req_idx];

  always_comb begin
    w_act  = used_q[idx_q] & run_q[idx_q];
    w_was  = pon_q[idx_q];
    w_mark = mark_q[idx_q];
    w_done = done_q[idx_q];
    if (w_was) begin
      w_next = !(w_mark >= MARK_W'(width_mem[idx_q]));
      w_base = w_mark;
    end else begin
      w_next = (w_mark == '0) || (w_mark >= MARK_W'(period_mem[idx_q]));
      // restart the period when a new pulse begins
      w_base = w_next ? '0 : w_mark;
    end
    w_sum      = {1'b0, w_base} + (MARK_W + 1)'(tick_q);
    w_new_mark = w_sum[MARK_W] ? MARK_MAX : w_sum[MARK_W-1:0];
    w_start    = w_act & w_next & ~w_was;
    w_end      = w_act & ~w_next & w_was;
    w_finish   = w_end && (w_done == total_mem[idx_q]);
  end

  // next flags and port bits
  always_comb begin
    port_d = port_q;
    used_d = used_q;
    run_d  = run_q;
    pon_d  = pon_q;
    if (cmd_i.exec) begin
      if (setup_ok) begin
        used_d[free_idx] = 1'b1;
        run_d[free_idx]  = 1'b0;
        pon_d[free_idx]  = 1'b0;
        port_d[chan_q]   = al_q;
      end
      if (start_ok) begin
        run_d[req_idx] = 1'b1;
      end
      if (stop_ok) begin
        used_d[req_idx] = 1'b0;
        run_d[req_idx]  = 1'b0;
      end
    end
    if (cmd_i.walk && (w_start || w_end)) begin
      pon_d[idx_q] = w_start;
      if (open_q) begin
        port_d[chan_mem[idx_q]] = w_start ^ al_mem[idx_q];
      end
      if (w_finish) begin
        run_d[idx_q] = 1'b0;
        if (!keep_mem[idx_q]) begin
          used_d[idx_q] = 1'b0;
        end
      end
    end
    if (cfg_we_i && (cfg_idx_e'(cfg_addr_i) == CFG_PORT_OPEN)) begin
      if (cfg_wdata_i[0] && !open_q) begin
        port_d = PORT_IDLE;
      end else if (!cfg_wdata_i[0] && open_q) begin
        used_d = '0;
        run_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      tick_q  <= TICK_W'(1);
      port_q  <= '0;
      used_q  <= '0;
      run_q   <= '0;
      pon_q   <= '0;
      idx_q   <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        mark_q[s] <= '0;
        done_q[s] <= '0;
      end
    end else begin
      port_q <= port_d;
      used_q <= used_d;
      run_q  <= run_d;
      pon_q  <= pon_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_PORT_OPEN: open_q <= cfg_wdata_i[0];
          CFG_TICK_MS:   tick_q <= cfg_wdata_i;
          default:       ;
        endcase
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.walk) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.exec && setup_ok) begin
        mark_q[free_idx] <= '0;
        done_q[free_idx] <= '0;
      end
      if (cmd_i.exec && start_ok) begin
        mark_q[req_idx] <= '0;
        done_q[req_idx] <= '0;
      end
      if (cmd_i.walk && w_act) begin
        mark_q[idx_q] <= w_new_mark;
        if (w_start && (w_done != COUNT_MAX)) begin
          done_q[idx_q] <= w_done + TIME_W'(1);
        end
      end
    end
  end

  // request capture, settings and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_e'(s_axis_tuser_i);
      slot_q      <= s_axis_tdata_i[2:0];
      chan_q      <= s_axis_tdata_i[5:3];
      al_q        <= s_axis_tdata_i[6];
      keep_q      <= s_axis_tdata_i[7];
      width_q     <= s_axis_tdata_i[23:8];
      period_q    <= s_axis_tdata_i[39:24];
      count_q     <= s_axis_tdata_i[55:40];
      res_acc_q   <= (req_e'(s_axis_tuser_i) == REQ_TICK);
      res_given_q <= '0;
    end
    if (cmd_i.exec) begin
      res_acc_q <= setup_ok | start_ok | stop_ok;
      if (setup_ok) begin
        res_given_q          <= free_idx;
        chan_mem[free_idx]   <= chan_q;
        al_mem[free_idx]     <= al_q;
        keep_mem[free_idx]   <= keep_q;
        width_mem[free_idx]  <= width_q;
        period_mem[free_idx] <= period_q;
        total_mem[free_idx]  <= (count_q == '0) ? TIME_W'(1) : count_q;
      end
    end
    if (cmd_i.push) begin
      tdata_q <= {5'b0, MASK_W'(run_q), MASK_W'(used_q), port_q, SLOT_W'(res_given_q)};
      tuser_q <= res_acc_q;
    end
  end

  assign m_axis_tdata_o = tdata_q;
  assign m_axis_tuser_o = tuser_q;

endmodule

/* src/multi_slot_pulse_train_generator_unit.sv */
// Channel     Direction  Handshake                        Payload
// s_axis      in         s_axis_tvalid_i/s_axis_tready_o  request
// m_axis      out        m_axis_tvalid_o/m_axis_tready_i  result
// cfg         in         cfg_we_i (no back-pressure)      register write
//
// A tick visits one slot per cycle through the shared slot update logic.
// Setup, start and stop go through the execute state instead of the slot walk.
// Reset clears all slot flags, marks and counts at once; no clearing pass.
// One result waits in the output register while the next request is taken;
// that request's result then holds in the controller until the output drains.
module multi_slot_pulse_train_generator_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mspt_pkg::CFG_A_W-1:0]  cfg_addr_i,
  input  logic [mspt_pkg::TICK_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // slot, channel, active_low, keep_after_done, width_ms, period_ms, pulse_count
  input  logic [mspt_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // req_type
  input  logic [mspt_pkg::S_USER_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // slot_given, port_value, used_mask, running_mask, zero fill
  output logic [mspt_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // accepted
  output logic [mspt_pkg::M_USER_W-1:0] m_axis_tuser_o
);
  import mspt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mspt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  mspt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
